/* sv/chtp_pkg.sv */
// shared types and constants for the chained hash table with node pool
// no dependencies
package chtp_pkg;

  localparam int CleanBuckets = 1024;
  localparam int DirtyBuckets = 1024;
  localparam int BlockBytes   = 4096;
  localparam int PoolNodes    = CleanBuckets + DirtyBuckets;
  localparam int NodeW        = $clog2(PoolNodes + 1);
  localparam int IdxW         = $clog2(PoolNodes);
  localparam int KeyW         = 48;
  localparam int SidW         = 32;
  localparam int BlkShift     = $clog2(BlockBytes);
  localparam int CleanW       = (CleanBuckets > 1) ? $clog2(CleanBuckets) : 1;
  localparam int DirtyW       = (DirtyBuckets > 1) ? $clog2(DirtyBuckets) : 1;
  localparam logic [NodeW-1:0] NilNode = NodeW'(PoolNodes);

  localparam logic [1:0] CmdLookup = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdDelete = 2'd2;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HEAD, S_NODE, S_CHECK, S_LINK, S_FREE, S_DONE
  } state_t;

  // node memory access from the sequencer
  typedef struct packed {
    logic             rd;
    logic [IdxW-1:0]  rd_addr;
    logic             wr_data;
    logic [IdxW-1:0]  wr_addr;
    logic [KeyW-1:0]  wr_key;
    logic [SidW-1:0]  wr_id;
    logic             wr_link;
    logic [IdxW-1:0]  link_addr;
    logic [NodeW-1:0] link_val;
  } node_req_t;

  function automatic logic [IdxW-1:0] head_slot(input logic [KeyW-1:0] key,
                                               input logic sel);
    logic [KeyW-1:0] blk;
    blk = key >> BlkShift;
    if (!sel) return IdxW'(blk & KeyW'(CleanBuckets - 1));
    return IdxW'(CleanBuckets) + IdxW'(blk & KeyW'(DirtyBuckets - 1));
  endfunction

endpackage

/* sv/chtp_node_mem.sv */
// node pool storage: keys, ids and links, registered reads
// depends on chtp_pkg
module chtp_node_mem import chtp_pkg::*; (
  input  logic             clk,
  input  node_req_t        req,
  output logic [KeyW-1:0]  rd_key,
  output logic [SidW-1:0]  rd_id,
  output logic [NodeW-1:0] rd_link
);

  logic [KeyW-1:0]  keys  [PoolNodes];
  logic [SidW-1:0]  ids   [PoolNodes];
  logic [NodeW-1:0] links [PoolNodes];

  always_ff @(posedge clk) begin
    if (req.wr_data) begin
      keys[req.wr_addr] <= req.wr_key;
      ids[req.wr_addr]  <= req.wr_id;
    end
    if (req.rd) begin
      rd_key <= keys[req.rd_addr];
      rd_id  <= ids[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_link) links[req.link_addr] <= req.link_val;
    if (req.rd) rd_link <= links[req.rd_addr];
  end

endmodule

/* sv/chained_hash_table_with_node_pool.sv */
// Each word walks its bucket chain one node at a time through the node memory
// (issue read, then compare). A lookup or delete stops at a match or at the end of
// the chain; an insert walks to the tail and links the fresh node there; a delete
// that matches takes one more step (S_LINK) to return the node to the free list.
// After reset a clearing pass rebuilds the free list and nulls the chain heads before
// the first word is taken.
// depends on chtp_pkg, chtp_node_mem
module chained_hash_table_with_node_pool import chtp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      command,
  input  logic            table_select,
  input  logic [KeyW-1:0] key_offset,
  input  logic [SidW-1:0] serial_id,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            found,
  output logic [SidW-1:0] result_id,
  output logic [1:0]      status
);

  state_t state, state_next;
  logic [NodeW-1:0] heads [PoolNodes];
  logic [NodeW-1:0] head_rd;
  logic [IdxW-1:0]  head_addr;
  logic [IdxW-1:0]  init_cnt;
  logic [1:0]       cmd;
  logic [KeyW-1:0]  key;
  logic [SidW-1:0]  sid;
  logic [IdxW-1:0]  slot;
  logic [NodeW-1:0] cur, prev, free_top, fresh;
  logic [IdxW:0]    steps;
  logic             head_wr;
  logic [NodeW-1:0] head_val;
  logic             res_found;
  logic [SidW-1:0]  res_id;
  logic [1:0]       res_stat;
  logic             res_load;
  node_req_t        req;
  logic [KeyW-1:0]  rd_key;
  logic [SidW-1:0]  rd_id;
  logic [NodeW-1:0] rd_link;

  chtp_node_mem u_mem (.clk, .req, .rd_key, .rd_id, .rd_link);

  // while idle the head read follows the incoming word
  assign head_addr = (state == S_IDLE) ? head_slot(key_offset, table_select) : slot;

  always_ff @(posedge clk) begin
    if (state == S_INIT) heads[init_cnt] <= NilNode;
    else if (head_wr) heads[slot] <= head_val;
    head_rd <= heads[head_addr];
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    req = '0;
    head_wr = 1'b0;
    head_val = NilNode;
    res_load = 1'b0;
    res_found = 1'b0;
    res_id = '0;
    res_stat = StatNotFound;
    case (state)
      S_INIT: begin
        req.wr_link = 1'b1;
        req.link_addr = init_cnt;
        req.link_val = NodeW'(init_cnt) + NodeW'(1);
        if (init_cnt == IdxW'(PoolNodes - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (in_valid && in_ready) state_next = S_HEAD;
      S_HEAD: begin
        // slot read landed this cycle
        if (cmd == CmdInsert) begin
          if (free_top == NilNode) begin
            res_load = 1'b1; res_stat = StatFull; state_next = S_DONE;
          end else begin
            req.rd = 1'b1;
            req.rd_addr = IdxW'(free_top);
            state_next = S_FREE;
          end
        end else if (cmd == CmdLookup || cmd == CmdDelete) begin
          if (head_rd == NilNode) begin
            res_load = 1'b1; state_next = S_DONE;
          end else begin
            req.rd = 1'b1; req.rd_addr = IdxW'(head_rd); state_next = S_CHECK;
          end
        end else begin
          res_load = 1'b1; state_next = S_DONE;
        end
      end
      S_FREE: begin
        // rd_link holds next free node; write the fresh node
        req.wr_data = 1'b1;
        req.wr_addr = IdxW'(free_top);
        req.wr_key = key;
        req.wr_id = sid;
        req.wr_link = 1'b1;
        req.link_addr = IdxW'(free_top);
        req.link_val = NilNode;
        if (head_rd == NilNode) begin
          head_wr = 1'b1; head_val = free_top;
          res_load = 1'b1; res_stat = StatOk; state_next = S_DONE;
        end else begin
          state_next = S_NODE;
        end
      end
      S_NODE: begin
        req.rd = 1'b1; req.rd_addr = IdxW'(cur); state_next = S_CHECK;
      end
      S_CHECK: begin
        if (cmd == CmdInsert) begin
          if (rd_link == NilNode || steps == (IdxW+1)'(PoolNodes)) begin
            req.wr_link = 1'b1; req.link_addr = IdxW'(cur); req.link_val = fresh;
            res_load = 1'b1; res_stat = StatOk; state_next = S_DONE;
          end else begin
            state_next = S_NODE;
          end
        end else if (rd_key == key) begin
          res_load = 1'b1; res_found = 1'b1; res_id = rd_id; res_stat = StatOk;
          state_next = S_DONE;
          if (cmd == CmdDelete) begin
            if (prev == NilNode) begin
              head_wr = 1'b1; head_val = rd_link;
            end else begin
              req.wr_link = 1'b1; req.link_addr = IdxW'(prev); req.link_val = rd_link;
            end
            state_next = S_LINK;
          end
        end else if (rd_link == NilNode || steps == (IdxW+1)'(PoolNodes - 1)) begin
          res_load = 1'b1; state_next = S_DONE;
        end else begin
          state_next = S_NODE;
        end
      end
      S_LINK: begin
        req.wr_link = 1'b1; req.link_addr = IdxW'(cur); req.link_val = free_top;
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_cnt <= '0;
      free_top <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) init_cnt <= init_cnt + IdxW'(1);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_DONE) out_valid <= 1'b1;
      if (state == S_FREE) free_top <= rd_link;
      if (state == S_LINK) free_top <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_ready) begin
      cmd <= command;
      key <= key_offset;
      sid <= serial_id;
      slot <= head_slot(key_offset, table_select);
    end
    if (res_load) begin
      found <= res_found;
      result_id <= res_id;
      status <= res_stat;
    end
    case (state)
      S_HEAD: begin
        cur <= head_rd; prev <= NilNode; steps <= '0;
      end
      S_FREE: begin
        fresh <= free_top; cur <= head_rd;
        steps <= '0;
      end
      S_CHECK: if (state_next == S_NODE) begin
        if (cmd != CmdInsert) prev <= cur;
        cur <= rd_link;
        steps <= steps + (IdxW+1)'(1);
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result not posted");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == StatFull) |-> !found) else $error("full with match");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(req.rd)) else $error("check without read");

endmodule

/* tb/testbench.sv */
// self-checking testbench for chained_hash_table_with_node_pool
// predicts every answer with its own copy of the chains and the free list
// depends on chtp_pkg and the block rtl
`timescale 1ns / 100ps

module testbench;
  import chtp_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic [1:0]      cmd;
    logic            sel;
    logic [KeyW-1:0] key;
    logic [SidW-1:0] sid;
  } hash_req_t;

  typedef struct packed {
    logic            hit;
    logic [SidW-1:0] id;
    logic [1:0]      stat;
  } hash_ans_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [1:0]      command = CmdLookup;
  logic            table_select = 1'b0;
  logic [KeyW-1:0] key_offset = '0;
  logic [SidW-1:0] serial_id = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            found;
  logic [SidW-1:0] result_id;
  logic [1:0]      status;

  chained_hash_table_with_node_pool i_dut (
    .clk, .rst, .in_valid, .in_ready, .command, .table_select, .key_offset,
    .serial_id, .out_valid, .out_ready, .found, .result_id, .status
  );

  // predictor state
  logic [NodeW-1:0] mdl_heads [PoolNodes];
  logic [KeyW-1:0]  mdl_keys  [PoolNodes];
  logic [SidW-1:0]  mdl_ids   [PoolNodes];
  logic [NodeW-1:0] mdl_links [PoolNodes];
  logic [NodeW-1:0] mdl_free;

  hash_req_t pending_words[$];
  hash_ans_t expected_answers[$];
  logic [KeyW-1:0] key_set[48];
  int  err_cnt = 0;
  int  words_taken = 0;
  bit  took = 0;
  int  burst_left = 0, gap_left = 0;
  bit  fast_mode = 0;
  int  hold_cnt = 0;
  bit  held_once = 0;
  logic [15:0] stall_pat = 16'hffff;
  int  pat_age = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int bucket_of(logic [KeyW-1:0] key, logic sel);
    logic [KeyW-1:0] blk;
    blk = key >> BlkShift;
    if (!sel) return int'(blk % CleanBuckets);
    return CleanBuckets + int'(blk % DirtyBuckets);
  endfunction

  task automatic reset_table();
    for (int i = 0; i < PoolNodes; i++) begin
      mdl_heads[i] = NilNode;
      mdl_keys[i]  = '0;
      mdl_ids[i]   = '0;
      mdl_links[i] = NodeW'(i + 1);
    end
    mdl_free = '0;
  endtask

  function automatic hash_ans_t apply_word(hash_req_t w);
    hash_ans_t a;
    int b;
    logic [NodeW-1:0] cur, prev, fresh;
    b = bucket_of(w.key, w.sel);
    a = '{hit: 1'b0, id: '0, stat: StatNotFound};
    case (w.cmd)
      CmdLookup: begin
        cur = mdl_heads[b];
        while (cur != NilNode) begin
          if (mdl_keys[cur] == w.key) begin
            a = '{hit: 1'b1, id: mdl_ids[cur], stat: StatOk};
            break;
          end
          cur = mdl_links[cur];
        end
      end
      CmdInsert: begin
        fresh = mdl_free;
        if (fresh == NilNode) begin
          a.stat = StatFull;
        end else begin
          mdl_free = mdl_links[fresh];
          mdl_keys[fresh] = w.key;
          mdl_ids[fresh] = w.sid;
          mdl_links[fresh] = NilNode;
          cur = mdl_heads[b];
          if (cur == NilNode) begin
            mdl_heads[b] = fresh;
          end else begin
            while (mdl_links[cur] != NilNode) cur = mdl_links[cur];
            mdl_links[cur] = fresh;
          end
          a.stat = StatOk;
        end
      end
      CmdDelete: begin
        prev = NilNode;
        cur = mdl_heads[b];
        while (cur != NilNode) begin
          if (mdl_keys[cur] == w.key) begin
            a = '{hit: 1'b1, id: mdl_ids[cur], stat: StatOk};
            if (prev == NilNode) mdl_heads[b] = mdl_links[cur];
            else mdl_links[prev] = mdl_links[cur];
            mdl_links[cur] = mdl_free;
            mdl_free = cur;
            break;
          end
          prev = cur;
          cur = mdl_links[cur];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[KeyW-1:0];
  endfunction

  task automatic push(logic [1:0] c, logic s, logic [KeyW-1:0] k, logic [SidW-1:0] id);
    pending_words.push_back('{cmd: c, sel: s, key: k, sid: id});
  endtask

  // input side: accept, predict
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_answers.push_back(apply_word('{cmd: command, sel: table_select,
                                              key: key_offset, sid: serial_id}));
      words_taken++;
      took = 1;
    end
  end

  // driver with bursts and gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      took = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        hash_req_t w;
        w = pending_words.pop_front();
        command <= w.cmd;
        table_select <= w.sel;
        key_offset <= w.key;
        serial_id <= w.sid;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          fast_mode = ($urandom_range(0, 3) == 0);
          gap_left = fast_mode ? 0 : $urandom_range(0, 7);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (!held_once && words_taken >= 400) begin
      held_once = 1;
      hold_cnt = 800;
      out_ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age = $urandom_range(16, 96);
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom());
      end
      pat_age--;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      out_ready <= stall_pat[0];
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected word: found=%0d result_id=%0h status=%0d",
               found, result_id, status);
        err_cnt++;
      end else begin
        hash_ans_t e;
        e = expected_answers.pop_front();
        if (found !== e.hit) begin
          $error("found: expected %0d, got %0d", e.hit, found);
          err_cnt++;
        end
        if (result_id !== e.id) begin
          $error("result_id: expected %0h, got %0h", e.id, result_id);
          err_cnt++;
        end
        if (status !== e.stat) begin
          $error("status: expected %0d, got %0d", e.stat, status);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [KeyW-1:0] ka, kb, kc;
    int r;
    reset_table();
    for (int i = 0; i < 48; i++) begin
      key_set[i] = rand_key();
      key_set[i][21:12] = 10'($urandom_range(0, 7));
    end
    // directed: empty table, unused command, extremes, duplicates, collisions
    ka = '1; kb = '0;
    kc = {26'h2aaaaaa, 10'd0, 12'h555};
    push(CmdLookup, 1'b0, ka, 32'h0);
    push(CmdDelete, 1'b1, ka, 32'h0);
    push(CmdUnused, 1'b0, kb, 32'hffffffff);
    push(CmdInsert, 1'b0, ka, 32'hffffffff);
    push(CmdInsert, 1'b1, ka, 32'h1);
    push(CmdInsert, 1'b0, kb, 32'h0);
    push(CmdInsert, 1'b1, kb, 32'h12345678);
    push(CmdLookup, 1'b0, ka, 32'h0);
    push(CmdLookup, 1'b1, ka, 32'h0);
    push(CmdLookup, 1'b1, kb, 32'h0);
    push(CmdInsert, 1'b0, ka, 32'hdeadbeef);
    push(CmdLookup, 1'b0, ka, 32'h0);
    push(CmdDelete, 1'b0, ka, 32'h0);
    push(CmdLookup, 1'b0, ka, 32'h0);
    push(CmdDelete, 1'b0, ka, 32'h0);
    push(CmdDelete, 1'b0, ka, 32'h0);
    push(CmdInsert, 1'b0, kc, 32'haaaa5555);
    push(CmdLookup, 1'b0, kc, 32'h0);
    push(CmdDelete, 1'b0, kb, 32'h0);
    push(CmdLookup, 1'b0, kc, 32'h0);
    push(CmdDelete, 1'b0, kc, 32'h0);
    push(CmdUnused, 1'b1, ka, 32'h0);
    push(CmdDelete, 1'b1, kb, 32'h0);
    // random mix over a colliding key set
    for (int i = 0; i < 1675; i++) begin
      r = $urandom_range(0, 99);
      ka = ($urandom_range(0, 9) == 0) ? rand_key() : key_set[$urandom_range(0, 47)];
      if (r < 40)      push(CmdInsert, 1'($urandom()), ka, $urandom());
      else if (r < 70) push(CmdDelete, 1'($urandom()), ka, $urandom());
      else if (r < 95) push(CmdLookup, 1'($urandom()), ka, $urandom());
      else             push(CmdUnused, 1'($urandom()), ka, $urandom());
    end
    push(CmdInsert, 1'b0, key_set[0], $urandom());
    push(CmdLookup, 1'b0, key_set[0], 32'h0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !in_valid && expected_answers.size() == 0);
    repeat (300) @(posedge clk);
    if (expected_answers.size() != 0) begin
      $error("%0d expected words never arrived", expected_answers.size());
      err_cnt++;
    end
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
